// ===== rtl/core/mmb_pkg.sv =====
package mmb_pkg;

  // fixed field widths
  localparam int DATA_W     = 32;
  localparam int POS_W      = 3;
  localparam int DIM_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // request kinds
  localparam logic [1:0] KIND_LOAD_A    = 2'd0;
  localparam logic [1:0] KIND_LOAD_B    = 2'd1;
  localparam logic [1:0] KIND_LOAD_BIAS = 2'd2;
  localparam logic [1:0] KIND_START     = 2'd3;

  // product modes
  localparam logic [1:0] MODE_AB  = 2'd0;
  localparam logic [1:0] MODE_ABT = 2'd1;
  localparam logic [1:0] MODE_ATB = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHAPE = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADD_BIAS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [POS_W-1:0]        elem_row;
    logic [POS_W-1:0]        elem_col;
    logic signed [DATA_W-1:0] elem_value;
  } mmb_in_t;

  typedef struct packed {
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]              status;
    logic                    saturated;
    logic                    last;
  } mmb_out_t;

  // controller to datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             wr_bias;
    logic             err_valid;
    logic [1:0]       err_code;
    logic             issue;
    logic [1:0]       mode;
    logic             bias_en;
    logic [POS_W-1:0] i;
    logic [POS_W-1:0] j;
    logic [POS_W-1:0] k;
    logic             first;
    logic             lastk;
    logic             last_elem;
  } mmb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_idle;
  } mmb_stat_t;

endpackage

// ===== rtl/core/mmb_ctrl.sv =====
module mmb_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  mmb_pkg::mmb_in_t                    in_data,
  input  logic                                cfg_we,
  input  logic [mmb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  mmb_pkg::mmb_stat_t                  stat,
  output logic                                busy,
  output mmb_pkg::mmb_cmd_t                   cmd
);

  localparam logic [mmb_pkg::DIM_W-1:0] MAX_D = mmb_pkg::DIM_W'(MAX_DIM);

  mmb_pkg::state_t state_r, state_nxt;

  logic [1:0]                  op_mode_r;
  logic                        add_bias_r;
  logic [mmb_pkg::DIM_W-1:0]   a_rows_r, a_cols_r, b_rows_r, b_cols_r;

  logic [1:0]                  mode_r, mode_nxt;
  logic                        bias_en_r, bias_en_nxt;
  logic [mmb_pkg::DIM_W-1:0]   inner_r, inner_nxt, rr_r, rr_nxt, rc_r, rc_nxt;
  logic [mmb_pkg::POS_W-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  logic [mmb_pkg::DIM_W-1:0]   lim_r, lim_c, res_r, res_c, inner_sel;
  logic                        res_ok, shape_ok, inner_ok, load_ok;
  logic [mmb_pkg::DIM_W-1:0]   row_x, col_x;
  logic                        k_end, j_end, i_end;

  function automatic logic dim_ok(input logic [mmb_pkg::DIM_W-1:0] d);
    dim_ok = (d != '0) && (d <= MAX_D);
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r  <= mmb_pkg::MODE_AB;
      add_bias_r <= 1'b0;
      a_rows_r   <= 4'd1;
      a_cols_r   <= 4'd1;
      b_rows_r   <= 4'd1;
      b_cols_r   <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        mmb_pkg::REG_OP_MODE:  op_mode_r  <= cfg_wdata[1:0];
        mmb_pkg::REG_ADD_BIAS: add_bias_r <= cfg_wdata[0];
        mmb_pkg::REG_A_ROWS:   a_rows_r   <= cfg_wdata;
        mmb_pkg::REG_A_COLS:   a_cols_r   <= cfg_wdata;
        mmb_pkg::REG_B_ROWS:   b_rows_r   <= cfg_wdata;
        mmb_pkg::REG_B_COLS:   b_cols_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // result shape and inner length of the current mode
  always_comb begin
    res_ok    = 1'b1;
    res_r     = a_rows_r;
    res_c     = b_cols_r;
    inner_sel = a_cols_r;
    inner_ok  = (a_cols_r == b_rows_r);
    case (op_mode_r)
      mmb_pkg::MODE_AB: begin
        res_r = a_rows_r; res_c = b_cols_r;
        inner_sel = a_cols_r; inner_ok = (a_cols_r == b_rows_r);
      end
      mmb_pkg::MODE_ABT: begin
        res_r = a_rows_r; res_c = b_rows_r;
        inner_sel = a_cols_r; inner_ok = (a_cols_r == b_cols_r);
      end
      mmb_pkg::MODE_ATB: begin
        res_r = a_cols_r; res_c = b_cols_r;
        inner_sel = a_rows_r; inner_ok = (a_rows_r == b_rows_r);
      end
      default: begin
        res_ok = 1'b0; inner_ok = 1'b0;
      end
    endcase
    shape_ok = dim_ok(a_rows_r) && dim_ok(a_cols_r) && dim_ok(b_rows_r)
               && dim_ok(b_cols_r) && inner_ok && res_ok;
  end

  // load bounds check
  always_comb begin
    row_x = {1'b0, in_data.elem_row};
    col_x = {1'b0, in_data.elem_col};
    lim_r = a_rows_r;
    lim_c = a_cols_r;
    case (in_data.kind)
      mmb_pkg::KIND_LOAD_A: begin lim_r = a_rows_r; lim_c = a_cols_r; end
      mmb_pkg::KIND_LOAD_B: begin lim_r = b_rows_r; lim_c = b_cols_r; end
      default:              begin lim_r = res_r;    lim_c = res_c;    end
    endcase
    load_ok = (row_x < lim_r) && (col_x < lim_c) && (row_x < MAX_D) && (col_x < MAX_D)
              && ((in_data.kind != mmb_pkg::KIND_LOAD_BIAS) || res_ok);
  end

  // loop ends
  assign k_end = ({1'b0, k_r} == inner_r - 4'd1);
  assign j_end = ({1'b0, j_r} == rc_r - 4'd1);
  assign i_end = ({1'b0, i_r} == rr_r - 4'd1);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    bias_en_nxt = bias_en_r;
    inner_nxt   = inner_r;
    rr_nxt      = rr_r;
    rc_nxt      = rc_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    cmd         = '0;
    cmd.mode    = mode_r;
    cmd.bias_en = bias_en_r;
    cmd.i       = i_r;
    cmd.j       = j_r;
    cmd.k       = k_r;
    case (state_r)
      mmb_pkg::ST_IDLE: begin
        if (start) begin
          if (in_data.kind == mmb_pkg::KIND_START) begin
            if (shape_ok) begin
              mode_nxt    = op_mode_r;
              bias_en_nxt = add_bias_r;
              inner_nxt   = inner_sel;
              rr_nxt      = res_r;
              rc_nxt      = res_c;
              i_nxt       = '0;
              j_nxt       = '0;
              k_nxt       = '0;
              state_nxt   = mmb_pkg::ST_RUN;
            end else begin
              cmd.err_valid = 1'b1;
              cmd.err_code  = mmb_pkg::STAT_SHAPE;
            end
          end else if (load_ok) begin
            cmd.wr_a    = (in_data.kind == mmb_pkg::KIND_LOAD_A);
            cmd.wr_b    = (in_data.kind == mmb_pkg::KIND_LOAD_B);
            cmd.wr_bias = (in_data.kind == mmb_pkg::KIND_LOAD_BIAS);
          end else begin
            cmd.err_valid = 1'b1;
            cmd.err_code  = mmb_pkg::STAT_RANGE;
          end
        end
      end
      mmb_pkg::ST_RUN: begin
        cmd.issue     = 1'b1;
        cmd.first     = (k_r == '0);
        cmd.lastk     = k_end;
        cmd.last_elem = k_end && j_end && i_end;
        if (!k_end) begin
          k_nxt = k_r + 3'd1;
        end else begin
          k_nxt = '0;
          if (!j_end) begin
            j_nxt = j_r + 3'd1;
          end else begin
            j_nxt = '0;
            if (!i_end) begin
              i_nxt = i_r + 3'd1;
            end else begin
              state_nxt = mmb_pkg::ST_DRAIN;
            end
          end
        end
      end
      mmb_pkg::ST_DRAIN: begin
        if (stat.pipe_idle) begin
          state_nxt = mmb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mmb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    bias_en_r <= bias_en_nxt;
    inner_r   <= inner_nxt;
    rr_r      <= rr_nxt;
    rc_r      <= rc_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    k_r       <= k_nxt;
  end

  assign busy = (state_r != mmb_pkg::ST_IDLE);

endmodule

// ===== rtl/core/mmb_dp.sv =====
module mmb_dp #(
  parameter int MAX_DIM    = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mmb_pkg::mmb_in_t   in_data,
  input  mmb_pkg::mmb_cmd_t  cmd,
  output mmb_pkg::mmb_stat_t stat,
  output logic               out_strobe,
  output mmb_pkg::mmb_out_t  out_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = $clog2(DEPTH);
  localparam int VB     = VALUE_BITS;
  localparam int PW     = 2 * VB;
  localparam int PS_W   = PW - 16;
  localparam int ACC_W  = PS_W + 4;
  localparam longint VMAX = (longint'(1) << (VB - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;

  typedef struct packed {
    logic                      first;
    logic                      lastk;
    logic                      last_elem;
    logic                      bias_en;
    logic [mmb_pkg::POS_W-1:0] i;
    logic [mmb_pkg::POS_W-1:0] j;
  } tag_t;

  logic signed [VB-1:0] mem_a    [DEPTH];
  logic signed [VB-1:0] mem_b    [DEPTH];
  logic signed [VB-1:0] mem_bias [DEPTH];

  logic [AW-1:0]        waddr, addr_a, addr_b, addr_bias;
  logic signed [VB-1:0] wval;
  longint               in_l, sum_l;

  logic                 v1_r, v2_r, v3_r, v4_r;
  tag_t                 t1_r, t2_r, t3_r, t4_r;
  logic signed [VB-1:0] a1_r, b1_r, bias1_r, bias2_r, bias3_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PS_W-1:0] shifted;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, sum_r;
  logic signed [VB-1:0] clip_v;
  logic                 clip_sat;

  logic                 out_strobe_r;
  mmb_pkg::mmb_out_t    out_data_r;

  function automatic logic [AW-1:0] addr_of(input logic [mmb_pkg::POS_W-1:0] row,
                                            input logic [mmb_pkg::POS_W-1:0] col);
    addr_of = AW'(int'(row) * MAX_DIM + int'(col));
  endfunction

  // load value clipped to the stored range
  always_comb begin
    in_l  = longint'(in_data.elem_value);
    waddr = addr_of(in_data.elem_row, in_data.elem_col);
    if (in_l > VMAX)      wval = VB'(VMAX);
    else if (in_l < VMIN) wval = VB'(VMIN);
    else                  wval = VB'(in_data.elem_value);
  end

  // operand addresses per mode
  always_comb begin
    addr_a    = (cmd.mode == mmb_pkg::MODE_ATB) ? addr_of(cmd.k, cmd.i) : addr_of(cmd.i, cmd.k);
    addr_b    = (cmd.mode == mmb_pkg::MODE_ABT) ? addr_of(cmd.j, cmd.k) : addr_of(cmd.k, cmd.j);
    addr_bias = addr_of(cmd.i, cmd.j);
  end

  // element stores
  always_ff @(posedge clk) begin
    if (cmd.wr_a) mem_a[waddr] <= wval;
    if (cmd.issue) a1_r <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) mem_b[waddr] <= wval;
    if (cmd.issue) b1_r <= mem_b[addr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_bias) mem_bias[waddr] <= wval;
    if (cmd.issue) bias1_r <= mem_bias[addr_bias];
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r && t3_r.lastk;
    end
  end

  // multiply, floor shift, accumulate
  assign shifted = prod_r[PW-1:16];
  assign acc_nxt = t2_r.first ? ACC_W'(shifted) : acc_r + ACC_W'(shifted);

  always_ff @(posedge clk) begin
    t1_r    <= '{first: cmd.first, lastk: cmd.lastk, last_elem: cmd.last_elem,
                 bias_en: cmd.bias_en, i: cmd.i, j: cmd.j};
    t2_r    <= t1_r;
    prod_r  <= PW'(a1_r) * PW'(b1_r);
    bias2_r <= bias1_r;
    t3_r    <= t2_r;
    bias3_r <= bias2_r;
    t4_r    <= t3_r;
    sum_r   <= acc_r + (t3_r.bias_en ? ACC_W'(bias3_r) : ACC_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  // saturation to the value range
  always_comb begin
    sum_l = longint'(sum_r);
    clip_sat = 1'b1;
    if (sum_l > VMAX)      clip_v = VB'(VMAX);
    else if (sum_l < VMIN) clip_v = VB'(VMIN);
    else begin
      clip_v   = VB'(sum_r);
      clip_sat = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= v4_r || cmd.err_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r) begin
      out_data_r.out_row   <= t4_r.i;
      out_data_r.out_col   <= t4_r.j;
      out_data_r.out_value <= mmb_pkg::DATA_W'(clip_v);
      out_data_r.status    <= mmb_pkg::STAT_OK;
      out_data_r.saturated <= clip_sat;
      out_data_r.last      <= t4_r.last_elem;
    end else begin
      out_data_r <= '{out_row: '0, out_col: '0, out_value: '0, status: cmd.err_code,
                      saturated: 1'b0, last: 1'b1};
    end
  end

  assign stat.pipe_idle = !(v1_r || v2_r || v3_r || v4_r);
  assign out_strobe     = out_strobe_r;
  assign out_data       = out_data_r;

endmodule

// ===== rtl/core/matrix_multiply_bias_top.sv =====
// Fixed-point matrix product with optional bias. Loads (kinds A, B, bias) give no result
// unless out of range; a start request computes rows x cols result elements at one
// multiply-accumulate per cycle, followed by pipeline drain through the store read,
// multiplier, accumulator, bias add and saturating result registers; busy stays high
// meanwhile. Results appear row-major, one cycle each on out_strobe, and the receiver
// cannot stall them, so they must be taken on the cycle they appear. Errors give a single
// result with last set.
module matrix_multiply_bias_top #(
  parameter int MAX_DIM    = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  mmb_pkg::mmb_in_t               in_data,
  output logic                           out_strobe,
  output mmb_pkg::mmb_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [mmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  mmb_pkg::mmb_cmd_t  cmd;
  mmb_pkg::mmb_stat_t stat;

  // sequencer and configuration
  mmb_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  // stores and arithmetic
  mmb_dp #(.MAX_DIM(MAX_DIM), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// ===== dv/mmb_checker.sv =====
`timescale 1ns / 1ps

module mmb_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  mmb_pkg::mmb_in_t               in_data,
  input  logic                           out_strobe,
  input  mmb_pkg::mmb_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [mmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mmb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending
);

  localparam int DIM = 8;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  // shadow of the block's stores and registers
  logic signed [mmb_pkg::DATA_W-1:0] mat_a    [DIM*DIM];
  logic signed [mmb_pkg::DATA_W-1:0] mat_b    [DIM*DIM];
  logic signed [mmb_pkg::DATA_W-1:0] mat_bias [DIM*DIM];
  longint                            acc_shadow;
  logic [1:0]                        mode_q;
  logic                              bias_q;
  logic [mmb_pkg::DIM_W-1:0]         ar_q, ac_q, br_q, bc_q;

  mmb_pkg::mmb_out_t result_q[$];

  function automatic mmb_pkg::mmb_out_t error_result(logic [1:0] code);
    mmb_pkg::mmb_out_t e;
    e = '0;
    e.status = code;
    e.last = 1'b1;
    return e;
  endfunction

  function automatic bit dim_ok(logic [mmb_pkg::DIM_W-1:0] d);
    return int'(d) >= 1 && int'(d) <= DIM;
  endfunction

  // result shape of the current mode, zero for the unused mode
  function automatic void result_shape(output int rr, output int rc);
    rr = 0;
    rc = 0;
    case (mode_q)
      mmb_pkg::MODE_AB: begin
        rr = int'(ar_q); rc = int'(bc_q);
      end
      mmb_pkg::MODE_ABT: begin
        rr = int'(ar_q); rc = int'(br_q);
      end
      mmb_pkg::MODE_ATB: begin
        rr = int'(ac_q); rc = int'(bc_q);
      end
      default: ;
    endcase
  endfunction

  // matrix product for one start request
  task automatic compute_product();
    int rr, rc, inner;
    longint x, y, sum, res;
    mmb_pkg::mmb_out_t e;
    bit sat;
    result_shape(rr, rc);
    inner = 0;
    if (mode_q == mmb_pkg::MODE_AB && ac_q == br_q) inner = int'(ac_q);
    else if (mode_q == mmb_pkg::MODE_ABT && ac_q == bc_q) inner = int'(ac_q);
    else if (mode_q == mmb_pkg::MODE_ATB && ar_q == br_q) inner = int'(ar_q);
    if (!dim_ok(ar_q) || !dim_ok(ac_q) || !dim_ok(br_q) || !dim_ok(bc_q) || inner == 0) begin
      result_q.push_back(error_result(mmb_pkg::STAT_SHAPE));
      return;
    end
    for (int i = 0; i < rr; i++) begin
      for (int j = 0; j < rc; j++) begin
        sum = 0;
        for (int k = 0; k < inner; k++) begin
          x = (mode_q == mmb_pkg::MODE_ATB) ? mat_a[k*DIM+i] : mat_a[i*DIM+k];
          y = (mode_q == mmb_pkg::MODE_ABT) ? mat_b[j*DIM+k] : mat_b[k*DIM+j];
          sum += (x * y) >>> 16;
        end
        if (bias_q) sum += mat_bias[i*DIM+j];
        acc_shadow = sum;
        sat = 1'b0;
        res = sum;
        if (sum > VMAX) begin
          res = VMAX; sat = 1'b1;
        end else if (sum < VMIN) begin
          res = VMIN; sat = 1'b1;
        end
        e = '0;
        e.out_row = i[mmb_pkg::POS_W-1:0];
        e.out_col = j[mmb_pkg::POS_W-1:0];
        e.out_value = res[mmb_pkg::DATA_W-1:0];
        e.status = mmb_pkg::STAT_OK;
        e.saturated = sat;
        e.last = (i == rr - 1) && (j == rc - 1);
        result_q.push_back(e);
      end
    end
  endtask

  // load requests store or fail, start requests compute
  task automatic predict_request(mmb_pkg::mmb_in_t req);
    int lr, lc, idx;
    idx = int'(req.elem_row) * DIM + int'(req.elem_col);
    case (req.kind)
      mmb_pkg::KIND_LOAD_A: begin
        lr = int'(ar_q); lc = int'(ac_q);
      end
      mmb_pkg::KIND_LOAD_B: begin
        lr = int'(br_q); lc = int'(bc_q);
      end
      mmb_pkg::KIND_LOAD_BIAS: result_shape(lr, lc);
      default: begin
        compute_product();
        return;
      end
    endcase
    if (int'(req.elem_row) >= lr || int'(req.elem_col) >= lc) begin
      result_q.push_back(error_result(mmb_pkg::STAT_RANGE));
      return;
    end
    case (req.kind)
      mmb_pkg::KIND_LOAD_A: mat_a[idx] = req.elem_value;
      mmb_pkg::KIND_LOAD_B: mat_b[idx] = req.elem_value;
      default:              mat_bias[idx] = req.elem_value;
    endcase
  endtask

  always @(posedge clk) begin
    mmb_pkg::mmb_out_t e;
    if (!rst_n) begin
      mode_q <= mmb_pkg::MODE_AB;
      bias_q <= 1'b0;
      ar_q <= 4'd1; ac_q <= 4'd1; br_q <= 4'd1; bc_q <= 4'd1;
      acc_shadow = 0;
      result_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          mmb_pkg::REG_OP_MODE:  mode_q <= cfg_wdata[1:0];
          mmb_pkg::REG_ADD_BIAS: bias_q <= cfg_wdata[0];
          mmb_pkg::REG_A_ROWS:   ar_q <= cfg_wdata;
          mmb_pkg::REG_A_COLS:   ac_q <= cfg_wdata;
          mmb_pkg::REG_B_ROWS:   br_q <= cfg_wdata;
          mmb_pkg::REG_B_COLS:   bc_q <= cfg_wdata;
          default: ;
        endcase
      end
      // accepted request
      if (start && !busy) predict_request(in_data);
      // result check
      if (out_strobe) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result row %0d col %0d value %0d status %0d", $time,
                   out_data.out_row, out_data.out_col, out_data.out_value, out_data.status);
          fail_count <= fail_count + 1;
        end else begin
          e = result_q.pop_front();
          if (out_data.out_row !== e.out_row || out_data.out_col !== e.out_col ||
              out_data.out_value !== e.out_value || out_data.status !== e.status ||
              out_data.saturated !== e.saturated || out_data.last !== e.last) begin
            $display("%0t: mismatch exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                     $time, e.out_row, e.out_col, e.out_value, e.status, e.saturated, e.last,
                     out_data.out_row, out_data.out_col, out_data.out_value, out_data.status,
                     out_data.saturated, out_data.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT = 1000000;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  mmb_pkg::mmb_in_t               in_data;
  logic                           out_strobe;
  mmb_pkg::mmb_out_t              out_data;
  logic                           cfg_we;
  logic [mmb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mmb_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             fail_count;
  int                             pending;
  int                             cycles;
  bit                             idle_on;
  int                             cur_mode, cur_ar, cur_ac, cur_br, cur_bc;

  matrix_multiply_bias_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mmb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("matrix_multiply_bias_top test failed");
      $finish;
    end
  end

  function automatic mmb_pkg::mmb_in_t make_req(logic [1:0] kind, int row, int col,
                                                logic [31:0] val);
    mmb_pkg::mmb_in_t r;
    r.kind = kind;
    r.elem_row = row[mmb_pkg::POS_W-1:0];
    r.elem_col = col[mmb_pkg::POS_W-1:0];
    r.elem_value = val;
    return r;
  endfunction

  // mix of extremes, unit-ish Q16.16 values and raw random bits
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // hand one request over, wait until the block takes it
  task automatic send(mmb_pkg::mmb_in_t r);
    in_data <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(int mode, int bias, int ar, int ac, int br, int bc);
    cur_mode = mode; cur_ar = ar; cur_ac = ac; cur_br = br; cur_bc = bc;
    cfg_we <= 1'b1;
    cfg_index <= mmb_pkg::REG_OP_MODE;
    cfg_wdata <= mode[mmb_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= mmb_pkg::REG_ADD_BIAS;
    cfg_wdata <= bias[mmb_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= mmb_pkg::REG_A_ROWS;
    cfg_wdata <= ar[mmb_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= mmb_pkg::REG_A_COLS;
    cfg_wdata <= ac[mmb_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= mmb_pkg::REG_B_ROWS;
    cfg_wdata <= br[mmb_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= mmb_pkg::REG_B_COLS;
    cfg_wdata <= bc[mmb_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // a load that fits the current shape of its matrix
  task automatic send_fitting_load();
    int kind, lr, lc;
    kind = $urandom_range(0, 2);
    lr = (kind == mmb_pkg::KIND_LOAD_B) ? cur_br : cur_ar;
    lc = (kind == mmb_pkg::KIND_LOAD_B) ? cur_bc : cur_ac;
    if (kind == mmb_pkg::KIND_LOAD_BIAS) begin
      lr = (cur_mode == mmb_pkg::MODE_ATB) ? cur_ac : cur_ar;
      lc = (cur_mode == mmb_pkg::MODE_ABT) ? cur_br : cur_bc;
    end
    if (lr < 1 || lr > 8) lr = 8;
    if (lc < 1 || lc > 8) lc = 8;
    send(make_req(kind[1:0], $urandom_range(0, lr - 1), $urandom_range(0, lc - 1),
                  pick_value()));
  endtask

  task automatic run_phase(int n, int mode, int bias, int ar, int ac, int br, int bc);
    int p, kind;
    set_config(mode, bias, ar, ac, br, bc);
    for (int t = 0; t < n; t++) begin
      p = $urandom_range(0, 99);
      kind = $urandom_range(0, 2);
      if (p < 12) send(make_req(mmb_pkg::KIND_START, $urandom_range(0, 7),
                                $urandom_range(0, 7), $urandom));
      else if (p < 22) send(make_req(kind[1:0], $urandom_range(0, 7),
                                     $urandom_range(0, 7), pick_value()));
      else send_fitting_load();
    end
    wait_idle();
  endtask

  function automatic int pick_dim();
    int p;
    p = $urandom_range(0, 29);
    if (p == 0) return 0;
    if (p == 1) return $urandom_range(9, 15);
    if (p < 5) return 8;
    return $urandom_range(1, 3);
  endfunction

  initial begin
    int mode, ar, ac, br, bc;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every store entry so no product ever reads an unwritten one
    set_config(mmb_pkg::MODE_AB, 0, 8, 8, 8, 8);
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) begin
        send(make_req(mmb_pkg::KIND_LOAD_A, r, c, pick_value()));
        send(make_req(mmb_pkg::KIND_LOAD_B, r, c, pick_value()));
        send(make_req(mmb_pkg::KIND_LOAD_BIAS, r, c, pick_value()));
      end
    wait_idle();

    // directed: full size in mode AB, the other modes, extremes, range and shape errors
    set_config(mmb_pkg::MODE_AB, 1, 8, 8, 8, 8);
    send(make_req(mmb_pkg::KIND_START, 0, 0, 0));
    wait_idle();
    set_config(mmb_pkg::MODE_ABT, 1, 2, 3, 4, 3);
    send(make_req(mmb_pkg::KIND_LOAD_A, 1, 2, 32'h7fff_ffff));
    send(make_req(mmb_pkg::KIND_LOAD_A, 0, 0, 32'h8000_0000));
    send(make_req(mmb_pkg::KIND_LOAD_B, 3, 2, 32'h8000_0000));
    send(make_req(mmb_pkg::KIND_LOAD_A, 7, 7, 32'hffff_ffff));
    send(make_req(mmb_pkg::KIND_LOAD_B, 4, 0, 32'h1234_5678));
    send(make_req(mmb_pkg::KIND_LOAD_BIAS, 1, 3, 32'h7fff_ffff));
    send(make_req(mmb_pkg::KIND_LOAD_BIAS, 2, 0, 32'h0001_0000));
    send(make_req(mmb_pkg::KIND_START, 7, 7, 32'hffff_ffff));
    wait_idle();
    set_config(mmb_pkg::MODE_ATB, 0, 3, 2, 3, 8);
    send(make_req(mmb_pkg::KIND_START, 0, 0, 0));
    send(make_req(mmb_pkg::KIND_LOAD_BIAS, 1, 7, 32'h0002_0000));
    wait_idle();
    // unused mode value
    set_config(3, 1, 2, 2, 2, 2);
    send(make_req(mmb_pkg::KIND_LOAD_BIAS, 0, 0, 32'h0001_0000));
    send(make_req(mmb_pkg::KIND_START, 0, 0, 0));
    wait_idle();
    set_config(mmb_pkg::MODE_AB, 0, 0, 2, 2, 2);
    send(make_req(mmb_pkg::KIND_LOAD_A, 0, 0, 32'h0001_0000));
    send(make_req(mmb_pkg::KIND_START, 0, 0, 0));
    wait_idle();
    set_config(mmb_pkg::MODE_AB, 1, 15, 15, 15, 15);
    send(make_req(mmb_pkg::KIND_START, 0, 0, 0));
    wait_idle();
    set_config(mmb_pkg::MODE_AB, 1, 2, 3, 2, 2);
    send(make_req(mmb_pkg::KIND_START, 0, 0, 0));
    wait_idle();

    // random phases, the last few without gaps
    for (int ph = 0; ph < 5; ph++) begin
      if (ph >= 3) idle_on = 1'b0;
      mode = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
      ar = pick_dim(); ac = pick_dim(); br = pick_dim(); bc = pick_dim();
      if ($urandom_range(0, 4) != 0) begin
        if (mode == mmb_pkg::MODE_AB) br = ac;
        else if (mode == mmb_pkg::MODE_ABT) bc = ac;
        else br = ar;
      end
      run_phase(25, mode, $urandom_range(0, 1), ar, ac, br, bc);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("matrix_multiply_bias_top test passed");
    end else begin
      $display("matrix_multiply_bias_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mmb_pkg.sv
rtl/core/mmb_ctrl.sv
rtl/core/mmb_dp.sv
rtl/core/matrix_multiply_bias_top.sv
dv/mmb_checker.sv
dv/testbench.sv
